// File: src/box_mean_filter_zero_pad_unit_macros.svh
// Assertion macros shared by the box mean filter RTL.
`ifndef BOX_MEAN_FILTER_ZERO_PAD_UNIT_MACROS_SVH
`define BOX_MEAN_FILTER_ZERO_PAD_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define BMF_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmf assertion failed");

// Next-cycle implication, checked out of reset.
`define BMF_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmf assertion failed");

`else

`define BMF_ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define BMF_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// File: src/bmf_pkg.sv
// Shared constants and types of the box mean filter.
`timescale 1ns / 1ps

package bmf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_MASK   = 31;
  localparam int MAX_HEIGHT = 2048;

  localparam int NUM_CH = 3;
  localparam int CH_W   = 8;
  localparam int PIX_W  = NUM_CH * CH_W;
  localparam int CH_MAX = (1 << CH_W) - 1;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);

  localparam int REG_DIM_W  = 12;
  localparam int REG_MASK_W = 5;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam int MASK_W = $clog2(MAX_MASK + 1);
  localparam int PAD_W  = $clog2(MAX_MASK / 2 + 1);
  localparam int DIV_W  = $clog2(MAX_MASK * MAX_MASK + 1);

  // line store: power-of-two ring of rows, at least MAX_MASK+1 deep
  localparam int SLOT_W     = $clog2(MAX_MASK + 1);
  localparam int ROWS_KEPT  = 1 << SLOT_W;
  localparam int LINE_DEPTH = ROWS_KEPT * MAX_WIDTH;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  localparam int COL_SUM_W = $clog2(MAX_MASK * CH_MAX + 1);
  // window sum briefly holds one extra column before the leaving one is dropped
  localparam int WIN_SUM_W = $clog2((MAX_MASK + 1) * MAX_MASK * CH_MAX + 1);
  localparam int CS_W      = NUM_CH * COL_SUM_W;

  localparam int STEP_W = $clog2(CH_W);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FRAME_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_FRAME_HEIGHT = cfg_idx_t'(1);
  localparam cfg_idx_t REG_MASK_SIZE    = cfg_idx_t'(2);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // effective geometry derived from the registers
  typedef struct packed {
    logic [WCNT_W-1:0] width;
    logic [HCNT_W-1:0] height;
    logic [PAD_W-1:0]  pad;
    logic [PAD_W-1:0]  ext;
    logic [DIV_W-1:0]  div;
    logic [DIV_W-1:0]  half;
  } geom_t;

  // work handed from the front to the back
  typedef struct packed {
    logic              has_px;
    logic [PIX_W-1:0]  px;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  wcol;
    logic              emit;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;
  } cmd_t;

endpackage

// File: src/bmf_if.sv
// Stream and configuration channel interfaces of the box mean filter.
`timescale 1ns / 1ps

interface bmf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [bmf_pkg::CH_W-1:0]  in_chan0;
  logic [bmf_pkg::CH_W-1:0]  in_chan1;
  logic [bmf_pkg::CH_W-1:0]  in_chan2;
  modport source (output valid, op, in_chan0, in_chan1, in_chan2, input ready);
  modport sink (input valid, op, in_chan0, in_chan1, in_chan2, output ready);
endinterface

interface bmf_out_if;
  logic                      valid;
  logic                      ready;
  logic [bmf_pkg::CH_W-1:0]  out_chan0;
  logic [bmf_pkg::CH_W-1:0]  out_chan1;
  logic [bmf_pkg::CH_W-1:0]  out_chan2;
  logic [bmf_pkg::ROW_W-1:0] out_row;
  logic [bmf_pkg::COL_W-1:0] out_col;
  logic                      frame_end;
  modport source (output valid, out_chan0, out_chan1, out_chan2, out_row, out_col,
                  frame_end, input ready);
  modport sink (input valid, out_chan0, out_chan1, out_chan2, out_row, out_col,
                frame_end, output ready);
endinterface

interface bmf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bmf_pkg::CFG_IDX_W-1:0]  index;
  logic [bmf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/box_mean_filter_zero_pad_unit.sv
// Top level of the streaming box mean filter with zero padding.
//
//  channel   dir   beat contents                                   accepted when
//  pix_in    in    op, in_chan0..2                                 valid && ready
//  pix_out   out   out_chan0..2, out_row, out_col, frame_end       valid && ready
//  cfg       in    index (0 width, 1 height, 2 mask), data         valid && ready
//
// An input beat passes through the front and lands in a 4-entry command queue.
// A pixel-only command is written to the line store as it is popped. A result adds
// each entering column (at a row start, the window's first columns), read from the
// line store one row per cycle, drops the leaving column sum and runs the 8-step divider.
// Reset (sync, active high) clears counters and handshakes; stores need no clearing.
// A stalled pix_out holds one finished result while the back starts the next.
`timescale 1ns / 1ps

module box_mean_filter_zero_pad_unit (
  input  logic       clk,
  input  logic       rst,
  bmf_in_if.sink     pix_in,
  bmf_out_if.source  pix_out,
  bmf_cfg_if.sink    cfg
);

  logic [bmf_pkg::REG_DIM_W-1:0]  frame_width;
  logic [bmf_pkg::REG_DIM_W-1:0]  frame_height;
  logic [bmf_pkg::REG_MASK_W-1:0] mask_size;

  bmf_pkg::geom_t             geom;
  logic [bmf_pkg::MASK_W-1:0] m_eff;
  logic                       cfg_wr;

  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  bmf_pkg::cmd_t cmd_in;
  bmf_pkg::cmd_t cmd_out;

  // config port never stalls; any write restarts the frame
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bmf_pkg::REG_DIM_W'(640);
      frame_height <= bmf_pkg::REG_DIM_W'(480);
      mask_size    <= bmf_pkg::REG_MASK_W'(3);
    end else if (cfg_wr) begin
      case (cfg.index)
        bmf_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg.data;
        bmf_pkg::REG_FRAME_HEIGHT: frame_height <= cfg.data;
        bmf_pkg::REG_MASK_SIZE:    mask_size    <= cfg.data[bmf_pkg::REG_MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: zero means one, oversize saturates
  always_comb begin
    if (frame_width == '0) begin
      geom.width = bmf_pkg::WCNT_W'(1);
    end else if (bmf_pkg::WCNT_W'(frame_width) > bmf_pkg::WCNT_W'(bmf_pkg::MAX_WIDTH)) begin
      geom.width = bmf_pkg::WCNT_W'(bmf_pkg::MAX_WIDTH);
    end else begin
      geom.width = bmf_pkg::WCNT_W'(frame_width);
    end
    if (frame_height == '0) begin
      geom.height = bmf_pkg::HCNT_W'(1);
    end else if (bmf_pkg::HCNT_W'(frame_height) > bmf_pkg::HCNT_W'(bmf_pkg::MAX_HEIGHT)) begin
      geom.height = bmf_pkg::HCNT_W'(bmf_pkg::MAX_HEIGHT);
    end else begin
      geom.height = bmf_pkg::HCNT_W'(frame_height);
    end
    if (mask_size == '0) begin
      m_eff = bmf_pkg::MASK_W'(1);
    end else if (bmf_pkg::MASK_W'(mask_size) > bmf_pkg::MASK_W'(bmf_pkg::MAX_MASK)) begin
      m_eff = bmf_pkg::MASK_W'(bmf_pkg::MAX_MASK);
    end else begin
      m_eff = bmf_pkg::MASK_W'(mask_size);
    end
    // pad rows/cols above-left, ext below-right (ext = pad + 1 for even masks)
    geom.pad  = bmf_pkg::PAD_W'((m_eff - bmf_pkg::MASK_W'(1)) >> 1);
    geom.ext  = bmf_pkg::PAD_W'(m_eff - bmf_pkg::MASK_W'(1) - bmf_pkg::MASK_W'(geom.pad));
    geom.div  = bmf_pkg::DIV_W'(m_eff) * bmf_pkg::DIV_W'(m_eff);
    geom.half = geom.div >> 1;
  end

  // front: position tracking and result scheduling per beat
  bmf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .restart (cfg_wr),
    .pix_in  (pix_in),
    .full    (full),
    .push    (push),
    .cmd     (cmd_in)
  );

  // decouples beat acceptance from the multi-cycle window math
  bmf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (cmd_in),
    .pop     (pop),
    .cmd_out (cmd_out),
    .full    (full),
    .empty   (empty)
  );

  // back: line store write, column/window sums, rounding divide, output register
  bmf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .cmd_valid (!empty),
    .cmd       (cmd_out),
    .pop       (pop),
    .pix_out   (pix_out)
  );

endmodule

// File: src/bmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/bmf_front.sv
// Front end: accepts beats, tracks input and result positions, issues commands.
`timescale 1ns / 1ps

module bmf_front (
  input  logic            clk,
  input  logic            rst,
  input  bmf_pkg::geom_t  geom,
  input  logic            restart,
  bmf_in_if.sink          pix_in,
  input  logic            full,
  output logic            push,
  output bmf_pkg::cmd_t   cmd
);

  logic [bmf_pkg::HCNT_W-1:0] in_row;
  logic [bmf_pkg::COL_W-1:0]  in_col;
  logic [bmf_pkg::HCNT_W-1:0] er;
  logic [bmf_pkg::COL_W-1:0]  ec;

  logic                       accept;
  logic                       px_ok;
  logic [bmf_pkg::WCNT_W-1:0] col_inc;
  logic [bmf_pkg::HCNT_W-1:0] nrow;
  logic [bmf_pkg::COL_W-1:0]  ncol;
  logic [bmf_pkg::HCNT_W-1:0] hm1;
  logic [bmf_pkg::WCNT_W-1:0] wm1;
  logic [bmf_pkg::HCNT_W-1:0] lr_raw;
  logic [bmf_pkg::HCNT_W-1:0] last_r;
  logic [bmf_pkg::WCNT_W-1:0] lc_raw;
  logic [bmf_pkg::WCNT_W-1:0] last_c;
  logic                       emit;
  logic [bmf_pkg::WCNT_W-1:0] ec_inc;
  logic [bmf_pkg::HCNT_W-1:0] er_n;
  logic [bmf_pkg::COL_W-1:0]  ec_n;
  logic                       done;

  assign pix_in.ready = !full;
  assign accept       = pix_in.valid && pix_in.ready;

  always_comb begin
    px_ok   = (pix_in.op == bmf_pkg::OP_PIXEL) && (in_row < geom.height);
    col_inc = {1'b0, in_col} + bmf_pkg::WCNT_W'(1);
    nrow    = in_row;
    ncol    = in_col;
    if (px_ok) begin
      if (col_inc == geom.width) begin
        ncol = '0;
        nrow = in_row + bmf_pkg::HCNT_W'(1);
      end else begin
        ncol = col_inc[bmf_pkg::COL_W-1:0];
      end
    end

    // last pixel the next result's window needs, clamped to the frame
    hm1    = geom.height - bmf_pkg::HCNT_W'(1);
    wm1    = geom.width - bmf_pkg::WCNT_W'(1);
    lr_raw = er + bmf_pkg::HCNT_W'(geom.ext);
    last_r = (lr_raw > hm1) ? hm1 : lr_raw;
    lc_raw = {1'b0, ec} + bmf_pkg::WCNT_W'(geom.ext);
    last_c = (lc_raw > wm1) ? wm1 : lc_raw;
    emit   = (nrow > last_r) || ((nrow == last_r) && ({1'b0, ncol} > last_c));

    ec_inc = {1'b0, ec} + bmf_pkg::WCNT_W'(1);
    if (ec_inc == geom.width) begin
      ec_n = '0;
      er_n = er + bmf_pkg::HCNT_W'(1);
    end else begin
      ec_n = ec_inc[bmf_pkg::COL_W-1:0];
      er_n = er;
    end
    done = emit && (er_n == geom.height);

    cmd.has_px = px_ok;
    cmd.px     = {pix_in.in_chan2, pix_in.in_chan1, pix_in.in_chan0};
    cmd.slot   = in_row[bmf_pkg::SLOT_W-1:0];
    cmd.wcol   = in_col;
    cmd.emit   = emit;
    cmd.row    = er[bmf_pkg::ROW_W-1:0];
    cmd.col    = ec;
    cmd.last   = done;
    push       = accept && (px_ok || emit);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row <= '0;
      in_col <= '0;
      er     <= '0;
      ec     <= '0;
    end else if (accept) begin
      if (done) begin
        in_row <= '0;
        in_col <= '0;
        er     <= '0;
        ec     <= '0;
      end else begin
        in_row <= nrow;
        in_col <= ncol;
        if (emit) begin
          er <= er_n;
          ec <= ec_n;
        end
      end
    end
  end

endmodule

// File: src/bmf_queue.sv
// Short command queue between front and back.
`timescale 1ns / 1ps

`include "box_mean_filter_zero_pad_unit_macros.svh"

module bmf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bmf_pkg::cmd_t cmd_in,
  input  logic          pop,
  output bmf_pkg::cmd_t cmd_out,
  output logic          full,
  output logic          empty
);

  bmf_pkg::cmd_t              slots [bmf_pkg::QUEUE_DEPTH];
  logic [bmf_pkg::QPTR_W-1:0] wptr;
  logic [bmf_pkg::QPTR_W-1:0] rptr;
  logic [bmf_pkg::QCNT_W-1:0] cnt;

  assign full    = (cnt == bmf_pkg::QCNT_W'(bmf_pkg::QUEUE_DEPTH));
  assign empty   = (cnt == '0);
  assign cmd_out = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + bmf_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + bmf_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + bmf_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        cnt <= cnt - bmf_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= cmd_in;
    end
  end

  `BMF_ASSERT_IMPLIES(a_no_pop_empty, clk, rst, pop, !empty)
  `BMF_ASSERT_IMPLIES(a_no_push_full, clk, rst, push, !full)
  `BMF_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, !empty)

endmodule

// File: src/bmf_back.sv
// Back end: line store, column sums, running window sum, divider, result register.
`timescale 1ns / 1ps

`include "box_mean_filter_zero_pad_unit_macros.svh"

module bmf_back (
  input  logic           clk,
  input  logic           rst,
  input  bmf_pkg::geom_t geom,
  input  logic           cmd_valid,
  input  bmf_pkg::cmd_t  cmd,
  output logic           pop,
  bmf_out_if.source      pix_out
);

  typedef enum logic [2:0] {
    S_IDLE, S_COL, S_CEND, S_LEAVE, S_LWAIT, S_DLOAD, S_DIV, S_DONE
  } state_t;

  state_t                       st;
  logic [bmf_pkg::ROW_W-1:0]    r;
  logic [bmf_pkg::COL_W-1:0]    c;
  logic                         last;
  logic [bmf_pkg::COL_W-1:0]    cc;
  logic [bmf_pkg::COL_W-1:0]    cc_end;
  logic [bmf_pkg::ROW_W-1:0]    rs;
  logic [bmf_pkg::ROW_W-1:0]    re;
  logic [bmf_pkg::ROW_W-1:0]    rd_row;
  logic                         pend;
  logic [bmf_pkg::COL_SUM_W-1:0] acc [bmf_pkg::NUM_CH];
  logic [bmf_pkg::WIN_SUM_W-1:0] win [bmf_pkg::NUM_CH];
  logic [bmf_pkg::WIN_SUM_W-1:0] rem [bmf_pkg::NUM_CH];
  logic [bmf_pkg::CH_W-1:0]      quo [bmf_pkg::NUM_CH];
  logic [bmf_pkg::STEP_W-1:0]    k;

  logic                        o_valid;
  logic [bmf_pkg::CH_W-1:0]    o_ch [bmf_pkg::NUM_CH];
  logic [bmf_pkg::ROW_W-1:0]   o_row;
  logic [bmf_pkg::COL_W-1:0]   o_col;
  logic                        o_last;

  logic                          line_we;
  logic [bmf_pkg::LINE_AW-1:0]   line_waddr;
  logic                          line_re;
  logic [bmf_pkg::LINE_AW-1:0]   line_raddr;
  logic [bmf_pkg::PIX_W-1:0]     line_rdata;
  logic                          cs_we;
  logic [bmf_pkg::CS_W-1:0]      cs_wdata;
  logic                          cs_re;
  logic [bmf_pkg::COL_W-1:0]     cs_raddr;
  logic [bmf_pkg::CS_W-1:0]      cs_rdata;

  logic [bmf_pkg::ROW_W-1:0]    rs_c;
  logic [bmf_pkg::ROW_W:0]      re_raw;
  logic [bmf_pkg::HCNT_W-1:0]   hm1;
  logic [bmf_pkg::ROW_W-1:0]    re_c;
  logic [bmf_pkg::WCNT_W-1:0]   enter_raw;
  logic                         enter_ok;
  logic [bmf_pkg::WCNT_W-1:0]   wm1;
  logic [bmf_pkg::COL_W-1:0]    start_end;
  logic                         leave_ok;
  logic [bmf_pkg::COL_SUM_W-1:0] col_total [bmf_pkg::NUM_CH];
  logic [bmf_pkg::WIN_SUM_W-1:0] dstep;
  logic                         ge [bmf_pkg::NUM_CH];
  logic                         out_free;

  always_comb begin
    rs_c   = (cmd.row < bmf_pkg::ROW_W'(geom.pad)) ? '0
             : cmd.row - bmf_pkg::ROW_W'(geom.pad);
    re_raw = {1'b0, cmd.row} + (bmf_pkg::ROW_W + 1)'(geom.ext);
    hm1    = geom.height - bmf_pkg::HCNT_W'(1);
    re_c   = (bmf_pkg::HCNT_W'(re_raw) > hm1) ? hm1[bmf_pkg::ROW_W-1:0]
             : re_raw[bmf_pkg::ROW_W-1:0];
    enter_raw = {1'b0, cmd.col} + bmf_pkg::WCNT_W'(geom.ext);
    enter_ok  = enter_raw < geom.width;
    wm1       = geom.width - bmf_pkg::WCNT_W'(1);
    start_end = (bmf_pkg::WCNT_W'(geom.ext) > wm1) ? wm1[bmf_pkg::COL_W-1:0]
                : bmf_pkg::COL_W'(geom.ext);
    leave_ok  = c > bmf_pkg::COL_W'(geom.pad);
    dstep     = bmf_pkg::WIN_SUM_W'(geom.div) << k;
    for (int i = 0; i < bmf_pkg::NUM_CH; i++) begin
      col_total[i] = acc[i]
                   + bmf_pkg::COL_SUM_W'(line_rdata[i*bmf_pkg::CH_W +: bmf_pkg::CH_W]);
      ge[i]        = rem[i] >= dstep;
    end
    out_free = !o_valid || pix_out.ready;

    pop        = (st == S_IDLE) && cmd_valid;
    line_we    = pop && cmd.has_px;
    line_waddr = {cmd.slot, cmd.wcol};
    line_re    = (st == S_COL);
    line_raddr = {rd_row[bmf_pkg::SLOT_W-1:0], cc};
    cs_we      = (st == S_CEND);
    cs_wdata   = {col_total[2], col_total[1], col_total[0]};
    cs_re      = (st == S_LEAVE) && leave_ok;
    cs_raddr   = c - bmf_pkg::COL_W'(geom.pad) - bmf_pkg::COL_W'(1);
  end

  bmf_ram #(.WIDTH(bmf_pkg::PIX_W), .DEPTH(bmf_pkg::LINE_DEPTH)) u_line_store (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (cmd.px),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  bmf_ram #(.WIDTH(bmf_pkg::CS_W), .DEPTH(bmf_pkg::MAX_WIDTH)) u_col_sums (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cc),
    .wdata (cs_wdata),
    .re    (cs_re),
    .raddr (cs_raddr),
    .rdata (cs_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= S_IDLE;
      pend    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      pend <= (st == S_COL);
      // a finished result loads the output register; otherwise it drains on ready
      if (st == S_DONE && out_free) begin
        o_valid <= 1'b1;
      end else if (pix_out.ready) begin
        o_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (cmd_valid && cmd.emit) begin
            r      <= cmd.row;
            c      <= cmd.col;
            last   <= cmd.last;
            rs     <= rs_c;
            re     <= re_c;
            rd_row <= rs_c;
            for (int i = 0; i < bmf_pkg::NUM_CH; i++) begin
              acc[i] <= '0;
            end
            if (cmd.col == '0) begin
              // row start: rebuild the window from its first columns
              for (int i = 0; i < bmf_pkg::NUM_CH; i++) begin
                win[i] <= '0;
              end
              cc     <= '0;
              cc_end <= start_end;
              st     <= S_COL;
            end else if (enter_ok) begin
              cc     <= enter_raw[bmf_pkg::COL_W-1:0];
              cc_end <= enter_raw[bmf_pkg::COL_W-1:0];
              st     <= S_COL;
            end else begin
              st <= S_LEAVE;
            end
          end
        end
        S_COL: begin
          if (pend) begin
            for (int i = 0; i < bmf_pkg::NUM_CH; i++) begin
              acc[i] <= col_total[i];
            end
          end
          if (rd_row == re) begin
            st <= S_CEND;
          end else begin
            rd_row <= rd_row + bmf_pkg::ROW_W'(1);
          end
        end
        S_CEND: begin
          for (int i = 0; i < bmf_pkg::NUM_CH; i++) begin
            win[i] <= win[i] + bmf_pkg::WIN_SUM_W'(col_total[i]);
            acc[i] <= '0;
          end
          if (cc != cc_end) begin
            cc     <= cc + bmf_pkg::COL_W'(1);
            rd_row <= rs;
            st     <= S_COL;
          end else begin
            st <= S_LEAVE;
          end
        end
        S_LEAVE: begin
          st <= leave_ok ? S_LWAIT : S_DLOAD;
        end
        S_LWAIT: begin
          for (int i = 0; i < bmf_pkg::NUM_CH; i++) begin
            win[i] <= win[i] - bmf_pkg::WIN_SUM_W'(
                      cs_rdata[i*bmf_pkg::COL_SUM_W +: bmf_pkg::COL_SUM_W]);
          end
          st <= S_DLOAD;
        end
        S_DLOAD: begin
          for (int i = 0; i < bmf_pkg::NUM_CH; i++) begin
            rem[i] <= win[i] + bmf_pkg::WIN_SUM_W'(geom.half);
          end
          k  <= bmf_pkg::STEP_W'(bmf_pkg::CH_W - 1);
          st <= S_DIV;
        end
        S_DIV: begin
          for (int i = 0; i < bmf_pkg::NUM_CH; i++) begin
            if (ge[i]) begin
              rem[i] <= rem[i] - dstep;
            end
            quo[i] <= {quo[i][bmf_pkg::CH_W-2:0], ge[i]};
          end
          if (k == '0) begin
            st <= S_DONE;
          end else begin
            k <= k - bmf_pkg::STEP_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            for (int i = 0; i < bmf_pkg::NUM_CH; i++) begin
              o_ch[i] <= quo[i];
            end
            o_row  <= r;
            o_col  <= c;
            o_last <= last;
            st     <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  assign pix_out.valid     = o_valid;
  assign pix_out.out_chan0 = o_ch[0];
  assign pix_out.out_chan1 = o_ch[1];
  assign pix_out.out_chan2 = o_ch[2];
  assign pix_out.out_row   = o_row;
  assign pix_out.out_col   = o_col;
  assign pix_out.frame_end = o_last;

  // k rests at zero in S_DONE, so ge compares each remainder with the divisor
  `BMF_ASSERT_IMPLIES(a_rows_in_window, clk, rst, st == S_COL, (rd_row >= rs) && (rd_row <= re))
  `BMF_ASSERT_IMPLIES(a_div_remainder, clk, rst, st == S_DONE, !(ge[0] || ge[1] || ge[2]))
  `BMF_ASSERT_NEXT(a_emit_starts, clk, rst, pop && cmd.emit, (st == S_COL) || (st == S_LEAVE))

endmodule
